/* sv/svm_pkg.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared word layouts, opcode and fault codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package svm_pkg;

   typedef enum logic [4:0] {
      K_CONST     = 5'd0,
      K_PUSH      = 5'd1,
      K_POP       = 5'd2,
      K_LOADVAR   = 5'd3,
      K_STOREVAR  = 5'd4,
      K_ADD       = 5'd5,
      K_SUB       = 5'd6,
      K_MUL       = 5'd7,
      K_DIV       = 5'd8,
      K_EQ        = 5'd9,
      K_NEQ       = 5'd10,
      K_GT        = 5'd11,
      K_LT        = 5'd12,
      K_GTE       = 5'd13,
      K_LTE       = 5'd14,
      K_PRINT     = 5'd15,
      K_JMP       = 5'd16,
      K_JMPFALSE  = 5'd17,
      K_LABEL     = 5'd18,
      K_CALL      = 5'd19,
      K_CALLPRINT = 5'd20,
      K_RET       = 5'd21
   } kind_type;

   typedef enum logic [2:0] {
      FAULT_OK    = 3'd0,
      FAULT_SOVF  = 3'd1,
      FAULT_SUNF  = 3'd2,
      FAULT_COVF  = 3'd3,
      FAULT_CUNF  = 3'd4,
      FAULT_DIV0  = 3'd5,
      FAULT_UNDEF = 3'd6,
      FAULT_OPC   = 3'd7
   } fault_type;

   typedef enum logic [1:0] {
      ST_CLEAR = 2'd0,
      ST_IDLE  = 2'd1,
      ST_EXEC  = 2'd2,
      ST_DIV   = 2'd3
   } state_type;

   typedef struct packed {
      logic [4:0]         kind;
      logic signed [31:0] immediate;
      logic [7:0]         var_slot;
      logic [15:0]        target;
   } req_word_type;

   typedef struct packed {
      logic [15:0]        next_ip;
      logic               print_valid;
      logic signed [31:0] print_value;
      logic               done_res;
      logic [2:0]         fault;
   } rsp_word_type;

   typedef struct packed {
      logic      clear_wr;
      logic      capture;
      logic      div_start;
      logic      commit;
      logic      apply;
      fault_type fault;
   } ctrl_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     fault_set;
      logic     depth_zero;
      logic     depth_lt2;
      logic     depth_full;
      logic     ret_empty;
      logic     ret_full;
      logic     var_defined;
      logic     tos_zero;
      logic     div_done;
      logic     clear_last;
   } dp_status_type;

endpackage

/* sv/svm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module svm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/svm_div.sv */
// ----------------------------------------------------------------------------
// Signed divider
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module svm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] shifted;
   logic [32:0] diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      shifted = {rem_ff, quo_ff[31]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
         cnt_in  = 6'd32;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // Keep the partial remainder when the trial subtraction goes negative.
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

/* sv/svm_ctrl.sv */
// ----------------------------------------------------------------------------
// Stack machine controller
// Sequences the clearing pass, instruction accept, fault checks, the divider
// wait and the hand-off of each result into the output register.
// ----------------------------------------------------------------------------
module svm_ctrl
   import svm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   fault_type check;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Fault check for the held instruction, in the order the machine defines.
   always_comb begin
      check = FAULT_OK;
      unique case (status.kind)
         K_CONST, K_PUSH: begin
            if (status.depth_full) check = FAULT_SOVF;
         end
         K_POP, K_STOREVAR, K_PRINT, K_CALLPRINT, K_JMPFALSE: begin
            if (status.depth_zero) check = FAULT_SUNF;
         end
         K_LOADVAR: begin
            if (!status.var_defined) check = FAULT_UNDEF;
            else if (status.depth_full) check = FAULT_SOVF;
         end
         K_ADD, K_SUB, K_MUL, K_EQ, K_NEQ, K_GT, K_LT, K_GTE, K_LTE: begin
            if (status.depth_lt2) check = FAULT_SUNF;
         end
         K_DIV: begin
            if (status.depth_lt2) check = FAULT_SUNF;
            else if (status.tos_zero) check = FAULT_DIV0;
         end
         K_JMP, K_LABEL: begin
            check = FAULT_OK;
         end
         K_CALL: begin
            if (status.ret_full) check = FAULT_COVF;
         end
         K_RET: begin
            if (status.ret_empty) check = FAULT_CUNF;
         end
         default: begin
            check = FAULT_OPC;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.fault = FAULT_OK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.fault_set) begin
               if (out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end else if (check != FAULT_OK) begin
               if (out_free) begin
                  cmd.commit = 1'b1;
                  cmd.fault  = check;
                  state_in   = ST_IDLE;
               end
            end else if (status.kind == K_DIV) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else if (out_free) begin
               cmd.commit = 1'b1;
               cmd.apply  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (status.div_done && out_free) begin
               cmd.commit = 1'b1;
               cmd.apply  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/svm_dpath.sv */
// ----------------------------------------------------------------------------
// Stack machine datapath
// Instruction register, cached top of stack, stack and variable memories,
// program counter, fault latch, ALU, divider and the result register.
// ----------------------------------------------------------------------------
module svm_dpath
   import svm_pkg::*;
#(
   parameter int DATA_STACK_DEPTH   = 1024,
   parameter int RETURN_STACK_DEPTH = 256,
   parameter int VARIABLE_SLOTS     = 256,
   parameter int ADDRESS_BITS       = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [15:0]   csr_wr_data,
   input  req_word_type  req_data,
   output rsp_word_type  rsp_data,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status
);

   localparam int DA = $clog2(DATA_STACK_DEPTH);
   localparam int DW = $clog2(DATA_STACK_DEPTH + 1);
   localparam int RA = $clog2(RETURN_STACK_DEPTH);
   localparam int RW = $clog2(RETURN_STACK_DEPTH + 1);
   localparam int VA = $clog2(VARIABLE_SLOTS);
   localparam int SW = (VA + 1 > 8) ? VA + 1 : 8;
   localparam int AB = ADDRESS_BITS;
   localparam int CW = (AB > 16) ? AB : 16;

   logic [4:0]    kind_ff;
   logic [31:0]   imm_ff;
   logic [7:0]    slot_ff;
   logic [AB-1:0] tgt_ff;
   logic [31:0]   tos_ff, tos_in;
   logic [DW-1:0] ddepth_ff, ddepth_in;
   logic [RW-1:0] rdepth_ff, rdepth_in;
   logic [AB-1:0] pc_ff, pc_in;
   fault_type     fault_ff, fault_in;
   logic [15:0]   plen_ff;
   logic [VA-1:0] clr_ff;
   rsp_word_type  rsp_ff, rsp_in;

   logic [31:0]   data_rd;
   logic [32:0]   var_rd;
   logic [AB-1:0] ret_rd;
   logic [31:0]   div_q;
   logic          div_done;

   logic [DW-1:0] ddepth_m1, ddepth_m2;
   logic [RW-1:0] rdepth_m1;
   logic [SW-1:0] req_slot_w, slot_w;
   logic          slot_in_range;
   logic [CW-1:0] req_tgt_w;

   logic          data_we, var_we, ret_we;
   logic [VA-1:0] var_wa;
   logic [32:0]   var_wd;
   logic [AB-1:0] next_seq, next_v, next_out;
   logic [CW-1:0] next_cw;
   logic          print_v;
   logic [31:0]   print_val;
   logic [31:0]   alu;
   logic [31:0]   mul_res;

   assign ddepth_m1     = ddepth_ff - DW'(1);
   assign ddepth_m2     = ddepth_ff - DW'(2);
   assign rdepth_m1     = rdepth_ff - RW'(1);
   assign req_slot_w    = SW'(req_data.var_slot);
   assign slot_w        = SW'(slot_ff);
   assign slot_in_range = slot_w < SW'(VARIABLE_SLOTS);
   assign req_tgt_w     = CW'(req_data.target);
   assign next_seq      = pc_ff + AB'(1);
   assign mul_res       = tos_ff * data_rd;

   svm_ram #(.WIDTH(32), .DEPTH(DATA_STACK_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (ddepth_m1[DA-1:0]),
      .wr_data (tos_ff),
      .rd_en   (cmd.capture),
      .rd_addr (ddepth_m2[DA-1:0]),
      .rd_data (data_rd)
   );

   svm_ram #(.WIDTH(33), .DEPTH(VARIABLE_SLOTS)) u_var_ram (
      .clock   (clock),
      .wr_en   (var_we),
      .wr_addr (var_wa),
      .wr_data (var_wd),
      .rd_en   (cmd.capture),
      .rd_addr (req_slot_w[VA-1:0]),
      .rd_data (var_rd)
   );

   svm_ram #(.WIDTH(AB), .DEPTH(RETURN_STACK_DEPTH)) u_ret_ram (
      .clock   (clock),
      .wr_en   (ret_we),
      .wr_addr (rdepth_ff[RA-1:0]),
      .wr_data (next_seq),
      .rd_en   (cmd.capture),
      .rd_addr (rdepth_m1[RA-1:0]),
      .rd_data (ret_rd)
   );

   svm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (data_rd),
      .divisor  (tos_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // First operand sits in the read register, second operand is the top of stack.
   always_comb begin
      unique case (kind_type'(kind_ff))
         K_ADD:   alu = data_rd + tos_ff;
         K_SUB:   alu = data_rd - tos_ff;
         K_MUL:   alu = mul_res;
         K_DIV:   alu = div_q;
         K_EQ:    alu = 32'($signed(data_rd) == $signed(tos_ff));
         K_NEQ:   alu = 32'($signed(data_rd) != $signed(tos_ff));
         K_GT:    alu = 32'($signed(data_rd) >  $signed(tos_ff));
         K_LT:    alu = 32'($signed(data_rd) <  $signed(tos_ff));
         K_GTE:   alu = 32'($signed(data_rd) >= $signed(tos_ff));
         default: alu = 32'($signed(data_rd) <= $signed(tos_ff));
      endcase
   end

   always_comb begin
      tos_in    = tos_ff;
      ddepth_in = ddepth_ff;
      rdepth_in = rdepth_ff;
      next_v    = next_seq;
      data_we   = 1'b0;
      var_we    = 1'b0;
      ret_we    = 1'b0;
      var_wa    = slot_w[VA-1:0];
      var_wd    = {1'b1, tos_ff};
      print_v   = 1'b0;
      print_val = '0;
      unique case (kind_type'(kind_ff))
         K_CONST, K_PUSH: begin
            data_we   = (ddepth_ff != '0);
            tos_in    = imm_ff;
            ddepth_in = ddepth_ff + DW'(1);
         end
         K_LOADVAR: begin
            data_we   = (ddepth_ff != '0);
            tos_in    = var_rd[31:0];
            ddepth_in = ddepth_ff + DW'(1);
         end
         K_POP: begin
            tos_in    = data_rd;
            ddepth_in = ddepth_m1;
         end
         K_STOREVAR: begin
            var_we    = slot_in_range;
            tos_in    = data_rd;
            ddepth_in = ddepth_m1;
         end
         K_ADD, K_SUB, K_MUL, K_DIV, K_EQ, K_NEQ, K_GT, K_LT, K_GTE, K_LTE: begin
            tos_in    = alu;
            ddepth_in = ddepth_m1;
         end
         K_PRINT, K_CALLPRINT: begin
            print_v   = 1'b1;
            print_val = tos_ff;
            tos_in    = data_rd;
            ddepth_in = ddepth_m1;
         end
         K_JMP: begin
            next_v = tgt_ff;
         end
         K_JMPFALSE: begin
            if (tos_ff == '0) next_v = tgt_ff;
            tos_in    = data_rd;
            ddepth_in = ddepth_m1;
         end
         K_CALL: begin
            ret_we    = 1'b1;
            rdepth_in = rdepth_ff + RW'(1);
            next_v    = tgt_ff;
         end
         K_RET: begin
            rdepth_in = rdepth_m1;
            next_v    = ret_rd;
         end
         default: begin
            next_v = next_seq;
         end
      endcase
      if (!(cmd.commit && cmd.apply)) begin
         data_we = 1'b0;
         var_we  = 1'b0;
         ret_we  = 1'b0;
         print_v = 1'b0;
         print_val = '0;
      end
      // The clearing pass after reset marks every variable slot undefined.
      if (cmd.clear_wr) begin
         var_we = 1'b1;
         var_wa = clr_ff;
         var_wd = '0;
      end
   end

   always_comb begin
      next_out = cmd.apply ? next_v : pc_ff;
      next_cw  = CW'(next_out);
      fault_in = (cmd.fault != FAULT_OK) ? cmd.fault : fault_ff;
      pc_in    = next_out;
      rsp_in.next_ip     = next_cw[15:0];
      rsp_in.print_valid = print_v;
      rsp_in.print_value = print_val;
      rsp_in.done_res    = next_cw >= CW'(plen_ff);
      rsp_in.fault       = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ddepth_ff <= '0;
         rdepth_ff <= '0;
         pc_ff     <= '0;
         fault_ff  <= FAULT_OK;
         plen_ff   <= '0;
         clr_ff    <= '0;
      end else begin
         if (csr_wr_en) plen_ff <= csr_wr_data;
         if (cmd.clear_wr) clr_ff <= clr_ff + VA'(1);
         if (cmd.commit) begin
            pc_ff    <= pc_in;
            fault_ff <= fault_in;
            if (cmd.apply) begin
               ddepth_ff <= ddepth_in;
               rdepth_ff <= rdepth_in;
            end
         end
      end
      if (cmd.capture) begin
         kind_ff <= req_data.kind;
         imm_ff  <= req_data.immediate;
         slot_ff <= req_data.var_slot;
         tgt_ff  <= req_tgt_w[AB-1:0];
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
         if (cmd.apply) tos_ff <= tos_in;
      end
   end

   assign rsp_data = rsp_ff;

   assign status.kind        = kind_type'(kind_ff);
   assign status.fault_set   = (fault_ff != FAULT_OK);
   assign status.depth_zero  = (ddepth_ff == '0);
   assign status.depth_lt2   = (ddepth_ff < DW'(2));
   assign status.depth_full  = (ddepth_ff == DW'(DATA_STACK_DEPTH));
   assign status.ret_empty   = (rdepth_ff == '0);
   assign status.ret_full    = (rdepth_ff == RW'(RETURN_STACK_DEPTH));
   assign status.var_defined = var_rd[32] && slot_in_range;
   assign status.tos_zero    = (tos_ff == '0);
   assign status.div_done    = div_done;
   assign status.clear_last  = (clr_ff == VA'(VARIABLE_SLOTS - 1));

endmodule

/* sv/stack_vm_execute_unit.sv */
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one stack-machine instruction per input word and returns the next
// fetch address, any printed value, the done flag and the sticky fault code.
// ----------------------------------------------------------------------------
// Each accepted instruction word yields exactly one result word. An ordinary
// instruction has an accept cycle, in which the stack, variable and return
// memories are read, and an execute step, in which the top of stack register,
// the depths and the memories are updated and the result is loaded into the
// output register. A divide then waits in the bit-serial divider, one
// quotient bit per cycle, until the divider hands over the quotient. The
// output register lets the block take the next word while the previous result
// still waits; the block only holds back an instruction if its result would
// overwrite one not yet taken. After reset the block runs a clearing pass
// that marks every variable undefined; no word is accepted during it, but the
// program length register may be written at any time. Program length must be
// written only while the block is idle. Once a fault is latched it stays, and
// every later instruction reports the unchanged address and the fault code.
module stack_vm_execute_unit
   import svm_pkg::*;
#(
   parameter int DATA_STACK_DEPTH   = 1024,
   parameter int RETURN_STACK_DEPTH = 256,
   parameter int VARIABLE_SLOTS     = 256,
   parameter int ADDRESS_BITS       = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [15:0]  csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller decides what happens each cycle from the status summary.
   svm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds all machine state and carries out the commands.
   svm_dpath #(
      .DATA_STACK_DEPTH   (DATA_STACK_DEPTH),
      .RETURN_STACK_DEPTH (RETURN_STACK_DEPTH),
      .VARIABLE_SLOTS     (VARIABLE_SLOTS),
      .ADDRESS_BITS       (ADDRESS_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
